FILE: hdl/bilinear_channel_resampler_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bilinear channel resampler
// ---------------------------------------------------------------------------
`ifndef BILINEAR_CHANNEL_RESAMPLER_CORE_DEFINES_SVH
`define BILINEAR_CHANNEL_RESAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define BCR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bcr_pkg.sv
// ---------------------------------------------------------------------------
// bcr_pkg
// Shared types and codes of the bilinear channel resampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcr_pkg;

    // request kinds carried in s_tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CHANNELS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SEL  = 3'd5;

    localparam int LD_W  = 18;  // load index width
    localparam int PIX_W = 8;
    localparam int DEN_W = 14;  // twice a 13-bit destination size

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic              valid;
        logic              is_sample;
        logic              err;
        logic [LD_W-1:0]   ld_addr;
        logic [PIX_W-1:0]  ld_val;
    } side_t;

endpackage

`default_nettype wire

FILE: hdl/bcr_ram.sv
// ---------------------------------------------------------------------------
// bcr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/bcr_div.sv
// ---------------------------------------------------------------------------
// bcr_div
// Pipelined restoring divider, one quotient bit per stage, x and y together.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcr_div #(
    parameter int NW  = 23,
    parameter int IPW = 11,
    parameter int F   = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire bcr_pkg::side_t              in_side,
    input  wire logic [NW-1:0]               in_num_x,
    input  wire logic [NW-1:0]               in_num_y,
    input  wire logic [bcr_pkg::DEN_W-1:0]   den_x,
    input  wire logic [bcr_pkg::DEN_W-1:0]   den_y,
    output bcr_pkg::side_t                   out_side,
    output logic [IPW+F-1:0]                 out_q_x,
    output logic [IPW+F-1:0]                 out_q_y
);

    localparam int QW = IPW + F;
    localparam int DW = bcr_pkg::DEN_W;

    logic [DW-1:0]   rx_in  [QW];
    logic [DW-1:0]   ry_in  [QW];
    logic [QW-1:0]   lx_in  [QW];
    logic [QW-1:0]   ly_in  [QW];
    logic [QW-1:0]   qx_in  [QW];
    logic [QW-1:0]   qy_in  [QW];
    bcr_pkg::side_t  sd_in  [QW];

    logic [DW-1:0]   rx_reg [QW];
    logic [DW-1:0]   ry_reg [QW];
    logic [QW-1:0]   lx_reg [QW];
    logic [QW-1:0]   ly_reg [QW];
    logic [QW-1:0]   qx_reg [QW];
    logic [QW-1:0]   qy_reg [QW];
    bcr_pkg::side_t  sd_reg [QW];

    // dividend is num << F; its top part is already below the divisor
    assign rx_in[0] = DW'(in_num_x >> IPW);
    assign ry_in[0] = DW'(in_num_y >> IPW);
    assign lx_in[0] = {in_num_x[IPW-1:0], {F{1'b0}}};
    assign ly_in[0] = {in_num_y[IPW-1:0], {F{1'b0}}};
    assign qx_in[0] = '0;
    assign qy_in[0] = '0;
    assign sd_in[0] = in_side;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]     trial_x, trial_y;
        logic            ge_x, ge_y;
        logic [DW-1:0]   rx_next, ry_next;

        if (k > 0) begin : g_link
            assign rx_in[k] = rx_reg[k-1];
            assign ry_in[k] = ry_reg[k-1];
            assign lx_in[k] = lx_reg[k-1];
            assign ly_in[k] = ly_reg[k-1];
            assign qx_in[k] = qx_reg[k-1];
            assign qy_in[k] = qy_reg[k-1];
            assign sd_in[k] = sd_reg[k-1];
        end

        always_comb begin
            trial_x = {rx_in[k], lx_in[k][QW-1]};
            trial_y = {ry_in[k], ly_in[k][QW-1]};
            ge_x    = trial_x >= {1'b0, den_x};
            ge_y    = trial_y >= {1'b0, den_y};
            rx_next = ge_x ? DW'(trial_x - {1'b0, den_x}) : DW'(trial_x);
            ry_next = ge_y ? DW'(trial_y - {1'b0, den_y}) : DW'(trial_y);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sd_reg[k].valid <= 1'b0;
            end else if (en) begin
                rx_reg[k] <= rx_next;
                ry_reg[k] <= ry_next;
                lx_reg[k] <= lx_in[k] << 1;
                ly_reg[k] <= ly_in[k] << 1;
                qx_reg[k] <= {qx_in[k][QW-2:0], ge_x};
                qy_reg[k] <= {qy_in[k][QW-2:0], ge_y};
                sd_reg[k] <= sd_in[k];
            end
        end
    end

    assign out_side = sd_reg[QW-1];
    assign out_q_x  = qx_reg[QW-1];
    assign out_q_y  = qy_reg[QW-1];

endmodule

`default_nettype wire

FILE: hdl/bcr_lerp.sv
// ---------------------------------------------------------------------------
// bcr_lerp
// Two-stage bilinear blend: horizontal pair of lerps, then vertical lerp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcr_lerp #(
    parameter int F = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire bcr_pkg::side_t              in_side,
    input  wire logic [bcr_pkg::PIX_W-1:0]   p00,
    input  wire logic [bcr_pkg::PIX_W-1:0]   p01,
    input  wire logic [bcr_pkg::PIX_W-1:0]   p10,
    input  wire logic [bcr_pkg::PIX_W-1:0]   p11,
    input  wire logic [F-1:0]                tx,
    input  wire logic [F-1:0]                ty,
    output bcr_pkg::side_t                   out_side,
    output logic signed [2*F+10:0]           out_acc
);

    localparam int TW   = F + 10;
    localparam int ACCW = 2 * F + 11;
    localparam logic signed [ACCW-1:0] HALF =
        {{(ACCW-2*F){1'b0}}, 1'b1, {(2*F-1){1'b0}}};

    logic signed [8:0]      d_top, d_bot;
    logic signed [TW-1:0]   prod_top, prod_bot, top_next, bot_next;
    logic signed [TW-1:0]   top_reg, bot_reg, diff;
    logic signed [ACCW-1:0] prod_v, acc_next, acc_reg;
    logic [F-1:0]           ty_reg;
    bcr_pkg::side_t         s1_reg, s2_reg;

    // stage 1: top = p00*2^F + (p01-p00)*tx, same for bottom row
    always_comb begin
        d_top    = $signed({1'b0, p01}) - $signed({1'b0, p00});
        d_bot    = $signed({1'b0, p11}) - $signed({1'b0, p10});
        prod_top = d_top * $signed({1'b0, tx});
        prod_bot = d_bot * $signed({1'b0, tx});
        top_next = $signed({2'b00, p00, {F{1'b0}}}) + prod_top;
        bot_next = $signed({2'b00, p10, {F{1'b0}}}) + prod_bot;
    end

    // stage 2: acc = top*2^F + (bot-top)*ty + half
    always_comb begin
        diff     = bot_reg - top_reg;
        prod_v   = diff * $signed({1'b0, ty_reg});
        acc_next = prod_v + $signed({top_reg, {F{1'b0}}}) + HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
        end else if (en) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            ty_reg  <= ty;
            s1_reg  <= in_side;
            acc_reg <= acc_next;
            s2_reg  <= s1_reg;
        end
    end

    assign out_side = s2_reg;
    assign out_acc  = acc_reg;

endmodule

`default_nettype wire

FILE: hdl/bilinear_channel_resampler_core.sv
// ---------------------------------------------------------------------------
// bilinear_channel_resampler_core
// Stores one 8-bit channel of a source image and resamples it bilinearly.
// ---------------------------------------------------------------------------
// The core takes one item per clock on the s_ side and keeps going as long as
// m_tready is high; a held result on the m_ side stalls the whole pipeline,
// nothing is dropped. Load items write one texel into the source store and
// give no result; sample items give exactly one result, in order. The divider
// produces one quotient bit per stage. The source store has four RAM copies
// so all four neighbours are read in the same cycle. Loads and samples reach
// the RAM at the same stage, so every sample sees exactly the loads that came
// before it. Configuration must only be written while idle; the core itself
// does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "bilinear_channel_resampler_core_defines.svh"

module bilinear_channel_resampler_core #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int FRACTION_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcr_pkg::CFG_DAT_W-1:0] cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: load_index[17:0], texel_ch0[25:18], texel_ch1[33:26],
    //          texel_ch2[41:34], texel_ch3[49:42], dest_x[61:50],
    //          dest_y[73:62], zero pad [79:74]
    input  wire logic [79:0] s_tdata,
    // s_tuser: req_type[0]
    input  wire logic [0:0]  s_tuser,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: pixel_value[7:0]
    output logic [7:0]       m_tdata,
    // m_tuser: coord_error[0]
    output logic [0:0]       m_tuser
);

    localparam int F     = FRACTION_BITS;
    localparam int MAXD  = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH
                                                            : MAX_SRC_HEIGHT;
    localparam int SWW   = $clog2(MAXD + 1);
    localparam int IPW   = $clog2(MAXD) + 1;
    localparam int QW    = IPW + F;
    localparam int NUMW  = 13 + SWW;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACCW  = 2 * F + 11;
    localparam int DW    = bcr_pkg::DEN_W;

    // ---------------- configuration registers
    logic [9:0]  src_width_reg, src_height_reg;
    logic [12:0] dst_width_reg, dst_height_reg;
    logic [2:0]  src_channels_reg;
    logic [1:0]  channel_select_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg      <= 10'd1;
            src_height_reg     <= 10'd1;
            dst_width_reg      <= 13'd1;
            dst_height_reg     <= 13'd1;
            src_channels_reg   <= 3'd1;
            channel_select_reg <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bcr_pkg::CFG_SRC_WIDTH:    src_width_reg      <= cfg_data[9:0];
                bcr_pkg::CFG_SRC_HEIGHT:   src_height_reg     <= cfg_data[9:0];
                bcr_pkg::CFG_DST_WIDTH:    dst_width_reg      <= cfg_data[12:0];
                bcr_pkg::CFG_DST_HEIGHT:   dst_height_reg     <= cfg_data[12:0];
                bcr_pkg::CFG_SRC_CHANNELS: src_channels_reg   <= cfg_data[2:0];
                bcr_pkg::CFG_CHANNEL_SEL:  channel_select_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, source sizes saturate at the store.
    logic [SWW-1:0] sw, sh;
    logic [12:0]    dw, dh;
    logic [DW-1:0]  den_x, den_y;

    always_comb begin
        if (src_width_reg == 10'd0)
            sw = SWW'(1);
        else if (src_width_reg > MAX_SRC_WIDTH)
            sw = SWW'(MAX_SRC_WIDTH);
        else
            sw = SWW'(src_width_reg);
        if (src_height_reg == 10'd0)
            sh = SWW'(1);
        else if (src_height_reg > MAX_SRC_HEIGHT)
            sh = SWW'(MAX_SRC_HEIGHT);
        else
            sh = SWW'(src_height_reg);
        dw    = (dst_width_reg == 13'd0) ? 13'd1 : dst_width_reg;
        dh    = (dst_height_reg == 13'd0) ? 13'd1 : dst_height_reg;
        den_x = {dw, 1'b0};
        den_y = {dh, 1'b0};
    end

    // Global advance: hold every stage while a result waits on the m_ side.
    logic pipe_en;
    logic m_tvalid_reg;
    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en;

    // ---------------- stage A: capture, pick channel, range check
    logic [11:0]    in_x, in_y;
    logic [7:0]     ch_pick;
    bcr_pkg::side_t a_side_next, a_side_reg;
    logic [11:0]    a_x_reg, a_y_reg;

    assign in_x = s_tdata[61:50];
    assign in_y = s_tdata[73:62];

    always_comb begin
        ch_pick = s_tdata[25:18];
        if (src_channels_reg > 3'd2 && {1'b0, channel_select_reg} < src_channels_reg) begin
            case (channel_select_reg)
                2'd0:    ch_pick = s_tdata[25:18];
                2'd1:    ch_pick = s_tdata[33:26];
                2'd2:    ch_pick = s_tdata[41:34];
                default: ch_pick = s_tdata[49:42];
            endcase
        end
        a_side_next.valid     = s_tvalid;
        a_side_next.is_sample = (s_tuser[0] == bcr_pkg::REQ_SAMPLE);
        a_side_next.err       = ({1'b0, in_x} >= dw) || ({1'b0, in_y} >= dh);
        a_side_next.ld_addr   = s_tdata[17:0];
        a_side_next.ld_val    = ch_pick;
    end

    // ---------------- stage B: (2c+1)*S
    bcr_pkg::side_t b_side_reg;
    logic [NUMW-1:0] b_numx_reg, b_numy_reg;

    // ---------------- stage C: subtract D, clamp at zero
    bcr_pkg::side_t c_side_reg;
    logic [NUMW-1:0] c_numx_reg, c_numy_reg;
    logic [NUMW-1:0] c_numx_next, c_numy_next;

    always_comb begin
        c_numx_next = (b_numx_reg > NUMW'(dw)) ? b_numx_reg - NUMW'(dw) : '0;
        c_numy_next = (b_numy_reg > NUMW'(dh)) ? b_numy_reg - NUMW'(dh) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_side_reg.valid <= 1'b0;
            b_side_reg.valid <= 1'b0;
            c_side_reg.valid <= 1'b0;
        end else if (pipe_en) begin
            a_side_reg <= a_side_next;
            a_x_reg    <= in_x;
            a_y_reg    <= in_y;
            b_side_reg <= a_side_reg;
            b_numx_reg <= NUMW'({a_x_reg, 1'b1}) * NUMW'(sw);
            b_numy_reg <= NUMW'({a_y_reg, 1'b1}) * NUMW'(sh);
            c_side_reg <= b_side_reg;
            c_numx_reg <= c_numx_next;
            c_numy_reg <= c_numy_next;
        end
    end

    // ---------------- divider: integer part and fraction together
    bcr_pkg::side_t q_side;
    logic [QW-1:0]  q_x, q_y;

    bcr_div #(
        .NW  (NUMW),
        .IPW (IPW),
        .F   (F)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_side  (c_side_reg),
        .in_num_x (c_numx_reg),
        .in_num_y (c_numy_reg),
        .den_x    (den_x),
        .den_y    (den_y),
        .out_side (q_side),
        .out_q_x  (q_x),
        .out_q_y  (q_y)
    );

    // ---------------- stage D: clamp to the edge, pick right/bottom neighbour
    logic [IPW-1:0] ipx, ipy, swm1, shm1, x0_next, y0_next, x1_next, y1_next;

    always_comb begin
        ipx     = q_x[QW-1:F];
        ipy     = q_y[QW-1:F];
        swm1    = IPW'(sw) - IPW'(1);
        shm1    = IPW'(sh) - IPW'(1);
        x0_next = (ipx > swm1) ? swm1 : ipx;
        y0_next = (ipy > shm1) ? shm1 : ipy;
        x1_next = (x0_next + IPW'(1) < IPW'(sw)) ? x0_next + IPW'(1) : swm1;
        y1_next = (y0_next + IPW'(1) < IPW'(sh)) ? y0_next + IPW'(1) : shm1;
    end

    bcr_pkg::side_t d_side_reg, e_side_reg, r_side_reg, p_side_reg;
    logic [IPW-1:0] d_x0_reg, d_x1_reg, d_y0_reg, d_y1_reg;
    logic [IPW-1:0] e_x0_reg, e_x1_reg;
    logic [AW-1:0]  e_row0_reg, e_row1_reg;
    logic [AW-1:0]  r_a00_reg, r_a01_reg, r_a10_reg, r_a11_reg;
    logic [F-1:0]   d_tx_reg, d_ty_reg, e_tx_reg, e_ty_reg;
    logic [F-1:0]   r_tx_reg, r_ty_reg, p_tx_reg, p_ty_reg;

    // stage E: row offsets; stage R: addresses; stage P: RAM data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_side_reg.valid <= 1'b0;
            e_side_reg.valid <= 1'b0;
            r_side_reg.valid <= 1'b0;
            p_side_reg.valid <= 1'b0;
        end else if (pipe_en) begin
            d_side_reg <= q_side;
            d_x0_reg   <= x0_next;
            d_x1_reg   <= x1_next;
            d_y0_reg   <= y0_next;
            d_y1_reg   <= y1_next;
            d_tx_reg   <= q_x[F-1:0];
            d_ty_reg   <= q_y[F-1:0];
            e_side_reg <= d_side_reg;
            e_row0_reg <= AW'(d_y0_reg) * AW'(sw);
            e_row1_reg <= AW'(d_y1_reg) * AW'(sw);
            e_x0_reg   <= d_x0_reg;
            e_x1_reg   <= d_x1_reg;
            e_tx_reg   <= d_tx_reg;
            e_ty_reg   <= d_ty_reg;
            r_side_reg <= e_side_reg;
            r_a00_reg  <= e_row0_reg + AW'(e_x0_reg);
            r_a01_reg  <= e_row0_reg + AW'(e_x1_reg);
            r_a10_reg  <= e_row1_reg + AW'(e_x0_reg);
            r_a11_reg  <= e_row1_reg + AW'(e_x1_reg);
            r_tx_reg   <= e_tx_reg;
            r_ty_reg   <= e_ty_reg;
            p_side_reg <= r_side_reg;
            p_tx_reg   <= r_tx_reg;
            p_ty_reg   <= r_ty_reg;
        end
    end

    // ---------------- source store: four copies, one per neighbour
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    p00, p01, p10, p11;

    // Write loads at the read stage; drop loads beyond the store.
    assign ram_we    = pipe_en && r_side_reg.valid && !r_side_reg.is_sample
                       && (32'(r_side_reg.ld_addr) < DEPTH);
    assign ram_waddr = AW'(r_side_reg.ld_addr);

    bcr_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_ram00 (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(r_side_reg.ld_val),
        .re(pipe_en), .raddr(r_a00_reg), .rdata(p00)
    );
    bcr_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_ram01 (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(r_side_reg.ld_val),
        .re(pipe_en), .raddr(r_a01_reg), .rdata(p01)
    );
    bcr_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_ram10 (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(r_side_reg.ld_val),
        .re(pipe_en), .raddr(r_a10_reg), .rdata(p10)
    );
    bcr_ram #(.WIDTH(8), .DEPTH(DEPTH), .AW(AW)) u_ram11 (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(r_side_reg.ld_val),
        .re(pipe_en), .raddr(r_a11_reg), .rdata(p11)
    );

    // ---------------- blend
    bcr_pkg::side_t          l_side;
    logic signed [ACCW-1:0]  l_acc;

    bcr_lerp #(.F(F)) u_lerp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_side  (p_side_reg),
        .p00      (p00),
        .p01      (p01),
        .p10      (p10),
        .p11      (p11),
        .tx       (p_tx_reg),
        .ty       (p_ty_reg),
        .out_side (l_side),
        .out_acc  (l_acc)
    );

    // ---------------- output register: round, saturate, force errors to zero
    logic [7:0] pix_next, m_tdata_reg;
    logic       m_tuser_reg;

    always_comb begin
        if (l_side.err)
            pix_next = 8'd0;
        else if (l_acc[ACCW-1:2*F+8] != '0)
            pix_next = 8'hFF;
        else
            pix_next = l_acc[2*F+7:2*F];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_tvalid_reg <= l_side.valid && l_side.is_sample;
            m_tdata_reg  <= pix_next;
            m_tuser_reg  <= l_side.err;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------- checks
    `BCR_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tdata == 8'd0, "coordinate error item carries a nonzero pixel")
    `BCR_ASSERT_NOW(a_we_adv, aclk, aresetn, ram_we,
        pipe_en && !r_side_reg.is_sample, "store written while stalled or by a sample")
    `BCR_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !pipe_en && r_side_reg.valid,
        r_side_reg.valid && $stable(r_a00_reg), "read stage moved during a stall")

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// Resampler regression bench
// Loads small source images, samples destination pixels bilinearly and
// checks every result against a bit-accurate predictor, with random idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class resample_board;
    byte unsigned texels[int];
    int unsigned src_w = 1, src_h = 1, dst_w = 1, dst_h = 1, chans = 1, sel = 0;
    logic [8:0] pending[$];
    int unsigned errors, checked;

    function int unsigned fix_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] val);
        case (idx)
            bcr_pkg::CFG_SRC_WIDTH:    src_w = val[9:0];
            bcr_pkg::CFG_SRC_HEIGHT:   src_h = val[9:0];
            bcr_pkg::CFG_DST_WIDTH:    dst_w = val;
            bcr_pkg::CFG_DST_HEIGHT:   dst_h = val;
            bcr_pkg::CFG_SRC_CHANNELS: chans = val[2:0];
            bcr_pkg::CFG_CHANNEL_SEL:  sel = val[1:0];
            default: ;
        endcase
    endfunction

    // source position: integer part and 16-bit fraction
    function void map_pos(longint unsigned c, longint unsigned s, longint unsigned d,
                          output longint unsigned ip, output longint unsigned fr);
        longint unsigned num, den;
        num = (2 * c + 1) * s;
        den = 2 * d;
        if (num <= d) begin
            ip = 0;
            fr = 0;
            return;
        end
        num -= d;
        ip = num / den;
        fr = ((num % den) << 16) / den;
    endfunction

    function longint unsigned pix(longint unsigned idx);
        return texels.exists(int'(idx)) ? texels[int'(idx)] : 0;
    endfunction

    function void note_item(logic req, logic [79:0] d);
        longint unsigned sw, sh, dw, dh, x, y, x0, x1, y0, y1, tx, ty, top, bot, acc;
        byte unsigned v;
        sw = fix_size(src_w, 512);
        sh = fix_size(src_h, 512);
        dw = fix_size(dst_w, 8191);
        dh = fix_size(dst_h, 8191);
        if (req == bcr_pkg::REQ_LOAD) begin
            v = d[25:18];
            if (chans > 2 && sel < chans) v = d[18 + 8 * sel +: 8];
            texels[int'(d[17:0])] = v;
            return;
        end
        x = d[61:50];
        y = d[73:62];
        if (x >= dw || y >= dh) begin
            pending.push_back({1'b1, 8'd0});
            return;
        end
        map_pos(x, sw, dw, x0, tx);
        map_pos(y, sh, dh, y0, ty);
        if (x0 > sw - 1) x0 = sw - 1;
        if (y0 > sh - 1) y0 = sh - 1;
        x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
        y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
        top = pix(y0 * sw + x0) * (65536 - tx) + pix(y0 * sw + x1) * tx;
        bot = pix(y1 * sw + x0) * (65536 - tx) + pix(y1 * sw + x1) * tx;
        acc = (top * (65536 - ty) + bot * ty + 64'h8000_0000) >> 32;
        if (acc > 255) acc = 255;
        pending.push_back({1'b0, acc[7:0]});
    endfunction

    function void check_result(logic [7:0] value, logic err);
        logic [8:0] want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result value=%0d err=%0d", value, err);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (want !== {err, value}) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected value=%0d err=%0d, got value=%0d err=%0d",
                         want[7:0], want[8], value, err);
        end
    endfunction
endclass

module tb;
    logic aclk = 0, aresetn = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic s_tvalid = 0, s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid, m_tready = 0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;

    resample_board board = new();
    bit quiet = 0;          // no idling near the end
    int unsigned hold_off = 0;
    longint unsigned cycles = 0;
    int unsigned n_loads = 0, n_samples = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    bilinear_channel_resampler_core u_dut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("timeout, %0d results still pending", board.pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin : sink
        int unsigned gap;
        @(posedge aclk);
        while (1) begin
            if (hold_off > 0) begin
                m_tready <= 0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11);
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= 13'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_reg(idx, 13'(val));
        cfg_valid <= 0;
    endtask

    // drop the input, wait for drain, then the pipeline depth for trailing loads
    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send_item(logic req, logic [79:0] d);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(req, d);
        if (req == bcr_pkg::REQ_LOAD) n_loads++; else n_samples++;
    endtask

    task automatic idle_input();
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [79:0] load_word(int unsigned idx);
        logic [79:0] d;
        d = 80'({$urandom, $urandom, $urandom});
        d[17:0] = 18'(idx);
        d[79:74] = '0;
        return d;
    endfunction

    function automatic logic [79:0] sample_word(int unsigned x, int unsigned y);
        logic [79:0] d;
        d = 80'({$urandom, $urandom, $urandom});
        d[61:50] = 12'(x);
        d[73:62] = 12'(y);
        d[79:74] = '0;
        return d;
    endfunction

    // fill a whole sw x sh image so no sample reads an unwritten entry
    task automatic fill_image(int unsigned sw, int unsigned sh);
        for (int unsigned i = 0; i < sw * sh; i++) send_item(bcr_pkg::REQ_LOAD, load_word(i));
    endtask

    // one setting: configure, fill, then sample n random pixels
    task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh, int unsigned ch, int unsigned cs,
                             int unsigned n);
        int unsigned x, y;
        drain();
        write_reg(bcr_pkg::CFG_SRC_WIDTH, sw);
        write_reg(bcr_pkg::CFG_SRC_HEIGHT, sh);
        write_reg(bcr_pkg::CFG_DST_WIDTH, dw);
        write_reg(bcr_pkg::CFG_DST_HEIGHT, dh);
        write_reg(bcr_pkg::CFG_SRC_CHANNELS, ch);
        write_reg(bcr_pkg::CFG_CHANNEL_SEL, cs);
        fill_image(sw == 0 ? 1 : sw, sh == 0 ? 1 : sh);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end else begin
                x = $urandom_range(0, dw == 0 ? 0 : dw - 1);
                y = $urandom_range(0, dh == 0 ? 0 : dh - 1);
            end
            // occasional reload of a texel
            if ($urandom_range(0, 7) == 0)
                send_item(bcr_pkg::REQ_LOAD, load_word($urandom_range(0, sw * sh - 1)));
            send_item(bcr_pkg::REQ_SAMPLE, sample_word(x, y));
        end
    endtask

    initial begin : stim
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset sizes, corners, out-of-range, load index at the store's last entry
        send_item(bcr_pkg::REQ_LOAD, load_word(0));
        send_item(bcr_pkg::REQ_SAMPLE, sample_word(0, 0));
        send_item(bcr_pkg::REQ_SAMPLE, sample_word(1, 0));
        send_item(bcr_pkg::REQ_SAMPLE, sample_word(4095, 4095));
        drain();
        write_reg(bcr_pkg::CFG_SRC_WIDTH, 2);
        write_reg(bcr_pkg::CFG_SRC_HEIGHT, 2);
        write_reg(bcr_pkg::CFG_DST_WIDTH, 4096);
        write_reg(bcr_pkg::CFG_DST_HEIGHT, 4096);
        write_reg(bcr_pkg::CFG_SRC_CHANNELS, 4);
        write_reg(bcr_pkg::CFG_CHANNEL_SEL, 3);
        fill_image(2, 2);
        send_item(bcr_pkg::REQ_LOAD, load_word(262143));
        send_item(bcr_pkg::REQ_SAMPLE, sample_word(0, 0));
        send_item(bcr_pkg::REQ_SAMPLE, sample_word(4095, 4095));
        send_item(bcr_pkg::REQ_SAMPLE, sample_word(2047, 2048));
        send_item(bcr_pkg::REQ_SAMPLE, sample_word(1023, 3071));
        // zero-size registers act as one
        run_phase(0, 0, 0, 0, 0, 0, 6);
        run_phase(5, 3, 4096, 1, 3, 3, 8);   // select beyond count keeps ch0
        run_phase(512, 1, 4096, 7, 4, 2, 40); // widest source, upscale
        run_phase(1, 512, 9, 4096, 4, 1, 40); // tallest source

        // random phases, small images
        for (int p = 0; p < 4; p++)
            run_phase($urandom_range(1, 12), $urandom_range(1, 12),
                      $urandom_range(1, 64), $urandom_range(1, 64),
                      $urandom_range(0, 7), $urandom_range(0, 3), 50);

        // back-pressure: receiver holds off while samples keep coming
        drain();
        hold_off = 300;
        for (int i = 0; i < 120; i++)
            send_item(bcr_pkg::REQ_SAMPLE, sample_word($urandom_range(0, 63),
                                                       $urandom_range(0, 63)));
        quiet = 1;
        run_phase(7, 9, 3000, 11, 4, 0, 150);
        idle_input();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("covered %0d loads and %0d samples, %0d results checked",
                 n_loads, n_samples, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: bilinear_channel_resampler_core.f
+incdir+hdl
hdl/bcr_pkg.sv
hdl/bcr_ram.sv
hdl/bcr_div.sv
hdl/bcr_lerp.sv
hdl/bilinear_channel_resampler_core.sv
bench/tb.sv
